// File: rtl/core/mandelbrot_escape_time_unit_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit assertion macros
// Shared concurrent assertion shorthands for the escape-time unit checkers.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/met_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Field widths, multiplier select codes and control/status bundles.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int C_W   = 32;  // c component width
  localparam int Z_W   = 36;  // z component width
  localparam int CNT_W = 8;   // iteration count width

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = 8'd20;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_RR = 2'd0;  // zr * zr
  localparam mul_sel_t MUL_II = 2'd1;  // zi * zi
  localparam mul_sel_t MUL_RI = 2'd2;  // zr * zi

  // Sequencer to datapath
  typedef struct packed {
    logic     idle;
    mul_sel_t mul_sel;
    logic     cap_rr;
    logic     cap_ii;
    logic     update;
    logic     finish;
  } met_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic limit_hit;
    logic mag_escape;
    logic sum_escape;
    logic out_free;
  } met_stat_t;

endpackage

// File: rtl/core/met_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time channel interfaces
// Valid/ready channels for incoming points and outgoing results.
// ----------------------------------------------------------------------------
interface met_point_if
  import met_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic signed [C_W-1:0] c_real;
  logic signed [C_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface met_result_if
  import met_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CNT_W-1:0]      iterations;
  logic                  inside_set;
  logic signed [Z_W-1:0] final_real;
  logic signed [Z_W-1:0] final_imag;

  modport source (output valid, output iterations, output inside_set,
                  output final_real, output final_imag, input ready);
  modport sink   (input valid, input iterations, input inside_set,
                  input final_real, input final_imag, output ready);
endinterface

// File: rtl/core/met_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shared multiplier
// Signed multiplier with a registered product, reused for both squares and zr*zi.
// ----------------------------------------------------------------------------
module met_mul #(
  parameter int OP_W = 30
) (
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output logic signed [2*OP_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/core/met_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time sequencer
// Steps one point through check, three products and update per iteration.
// ----------------------------------------------------------------------------
module met_ctrl
  import met_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  met_stat_t stat,
  output met_ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MRR   = 3'd2;
  localparam logic [2:0] S_MII   = 3'd3;
  localparam logic [2:0] S_MRI   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next   = state;
    ctrl         = '0;
    ctrl.mul_sel = MUL_RR;
    case (state)
      S_IDLE: begin
        ctrl.idle = 1'b1;
        if (in_fire) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.limit_hit || stat.mag_escape) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MRR;
        end
      end
      S_MRR: begin
        ctrl.mul_sel = MUL_RR;
        state_next   = S_MII;
      end
      S_MII: begin
        ctrl.mul_sel = MUL_II;
        ctrl.cap_rr  = 1'b1;
        state_next   = S_MRI;
      end
      S_MRI: begin
        ctrl.mul_sel = MUL_RI;
        ctrl.cap_ii  = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        // product register holds zr*zi here
        if (stat.sum_escape) begin
          state_next = S_DONE;
        end else begin
          ctrl.update = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Iterates z = z*z + c from z = 0 for one point and reports the escape count.
// ----------------------------------------------------------------------------
// Each transaction on the point channel carries c in signed fixed point with
// FRAC_BITS fraction bits. The unit runs z = z*z + c until the step count
// reaches max_iterations or |z|^2 >= 4, then presents the count, an inside
// flag (count equals the limit) and the last z with 8 integer bits. One point
// is worked on at a time and the point channel is not ready meanwhile. All
// three products of an iteration (zr^2, zi^2, zr*zi) go through one shared
// registered multiplier, so an iteration steps through a check, the three
// products in turn and an update. A consumer that has not taken the previous
// result holds the unit in its final state until it does. The result sits in
// an output register, so a new point is taken while the previous result still
// waits for the consumer. max_iterations resets to 20; a limit of 0 returns at
// once with count 0 and the inside flag set.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit
  import met_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic                clk,
  input  logic                rst,
  met_point_if.sink           point,
  met_result_if.source        result,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata
);

  // Once both components are below 2 in magnitude they fit in this width.
  localparam int OP_W   = FRAC_BITS + 2;
  localparam int PROD_W = 2 * OP_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [Z_W-1:0] TWO     = Z_W'(1) <<< (FRAC_BITS + 1);
  localparam logic signed [Z_W-1:0] NEG_TWO = -TWO;
  localparam logic [SUM_W-1:0]      ESC_SQ  = SUM_W'(1) << (2 * FRAC_BITS + 2);

  met_ctrl_t ctrl;
  met_stat_t stat;
  logic      in_fire;

  // Working state
  logic [CNT_W-1:0]        max_iter;
  logic [CNT_W-1:0]        step_count;
  logic signed [Z_W-1:0]   z_re;
  logic signed [Z_W-1:0]   z_im;
  logic signed [C_W-1:0]   c_re;
  logic signed [C_W-1:0]   c_im;
  logic signed [PROD_W-1:0] p_rr;
  logic signed [PROD_W-1:0] p_ii;

  // Multiplier operands and product
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  // Update terms
  logic [SUM_W-1:0]         mag_sq;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] re_term;
  logic signed [PROD_W-1:0] im_term;
  logic signed [Z_W-1:0]    z_re_next;
  logic signed [Z_W-1:0]    z_im_next;

  // Output register
  logic                  res_valid;
  logic [CNT_W-1:0]      res_iter;
  logic                  res_inside;
  logic signed [Z_W-1:0] res_re;
  logic signed [Z_W-1:0] res_im;

  assign point.ready = ctrl.idle;
  assign in_fire     = point.valid && point.ready;

  met_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  // Select operands; truncation is exact because the magnitude check passed.
  always_comb begin
    case (ctrl.mul_sel)
      MUL_RR: begin
        mul_a = z_re[OP_W-1:0];
        mul_b = z_re[OP_W-1:0];
      end
      MUL_II: begin
        mul_a = z_im[OP_W-1:0];
        mul_b = z_im[OP_W-1:0];
      end
      MUL_RI: begin
        mul_a = z_re[OP_W-1:0];
        mul_b = z_im[OP_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  met_mul #(.OP_W(OP_W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Both squares are non-negative, so an unsigned sum is exact.
  assign mag_sq  = {1'b0, p_rr} + {1'b0, p_ii};
  assign diff    = p_rr - p_ii;
  // Arithmetic shifts round toward minus infinity; 2*zr*zi folds into the shift.
  assign re_term = diff >>> FRAC_BITS;
  assign im_term = prod >>> (FRAC_BITS - 1);
  assign z_re_next = Z_W'(re_term) + Z_W'(c_re);
  assign z_im_next = Z_W'(im_term) + Z_W'(c_im);

  assign stat.limit_hit  = (step_count >= max_iter);
  assign stat.mag_escape = (z_re >= TWO) || (z_re <= NEG_TWO) ||
                           (z_im >= TWO) || (z_im <= NEG_TWO);
  assign stat.sum_escape = (mag_sq >= ESC_SQ);
  assign stat.out_free   = !res_valid || result.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iter <= cfg_wdata;
    end
  end

  // Latch c, clear z and the step count on a new point; advance both each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (in_fire) begin
      step_count <= '0;
    end else if (ctrl.update) begin
      step_count <= step_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      c_re <= point.c_real;
      c_im <= point.c_imag;
      z_re <= '0;
      z_im <= '0;
    end else if (ctrl.update) begin
      z_re <= z_re_next;
      z_im <= z_im_next;
    end
    if (ctrl.cap_rr) begin
      p_rr <= prod;
    end
    if (ctrl.cap_ii) begin
      p_ii <= prod;
    end
  end

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.finish) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      res_iter   <= step_count;
      res_inside <= (step_count == max_iter);
      res_re     <= z_re;
      res_im     <= z_im;
    end
  end

  assign result.valid      = res_valid;
  assign result.iterations = res_iter;
  assign result.inside_set = res_inside;
  assign result.final_real = res_re;
  assign result.final_imag = res_im;

endmodule

// File: rtl/core/met_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time port checker
// Port-level checks of the escape-time unit, attached by bind.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_unit_macros.svh"

module met_checker
  import met_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CNT_W-1:0]      out_iterations,
  input logic                  out_inside,
  input logic signed [Z_W-1:0] out_real,
  input logic                  cfg_we,
  input logic [CNT_W-1:0]      cfg_wdata
);

  logic [CNT_W-1:0] limit;

  // Track the iteration limit as written on the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  `MET_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `MET_ASSERT_NOW(a_inside_at_limit, clk, rst, out_valid && out_inside, out_iterations == limit, "inside flag off limit")
  `MET_ASSERT_NOW(a_outside_below_limit, clk, rst, out_valid && !out_inside, out_iterations < limit, "count past limit")
  `MET_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_real), "result dropped")

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (point.valid),
  .in_ready       (point.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_iterations (result.iterations),
  .out_inside     (result.inside_set),
  .out_real       (result.final_real),
  .cfg_we         (cfg_we),
  .cfg_wdata      (cfg_wdata)
);

// File: tb/mandelbrot_escape_time_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit testbench
// Streams complex points through the unit and checks every escape result
// against a cycle-free model of the iteration. Corner points run first, then
// the iteration limit is taken to 1, 0 and 255, and four random phases mix
// points near the set boundary with full-range values while the point and
// result channels idle and stall at different rates.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit_tb;
  import met_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int CLK_HALF  = 4;
  localparam int RST_CYCLES = 8;
  localparam int MAX_PRINTS = 40;

  // Escape bounds: a component at 2 or more escapes at once, otherwise the
  // squared magnitude is compared against 4 with 2*FRAC_BITS fraction bits.
  localparam longint ESCAPE_MAG = longint'(2) << FRAC_BITS;
  localparam longint ESCAPE_SQ  = longint'(4) << (2 * FRAC_BITS);

  localparam int signed Q_ONE = 1 << FRAC_BITS;
  localparam int signed C_MIN = 32'sh8000_0000;
  localparam int signed C_MAX = 32'sh7fff_ffff;

  // Random points near the set: real in [-2.25, 0.75], imag in [-1.5, 1.5].
  localparam int unsigned NEAR_SPAN   = 3 * (1 << FRAC_BITS);
  localparam int signed   NEAR_RE_LOW = 9 << (FRAC_BITS - 2);
  localparam int signed   NEAR_IM_LOW = (3 << FRAC_BITS) / 2;

  typedef struct {
    logic [CNT_W-1:0]      iterations;
    logic                  inside_set;
    logic signed [Z_W-1:0] final_real;
    logic signed [Z_W-1:0] final_imag;
  } escape_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  met_point_if  point_ch ();
  met_result_if result_ch ();

  mandelbrot_escape_time_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .point    (point_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Local copy of the iteration limit, tracking every register write.
  logic [CNT_W-1:0] iter_limit = MAX_ITER_RESET;

  escape_result_t pending_results[$];

  int idle_pct  = 0;  // chance in 100 that the point side holds back a cycle
  int stall_pct = 0;  // chance in 100 that the result side drops ready
  int mismatch_count = 0;
  int points_sent    = 0;
  int results_seen   = 0;
  int inside_seen    = 0;
  int limits_used    = 1;
  int deepest_count  = 0;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Iterate z = z*z + c from z = 0 exactly as the unit does: products are
  // floored back to FRAC_BITS fraction bits and the escape test runs before
  // each step.
  function automatic escape_result_t predict_escape(input logic signed [C_W-1:0] c_re,
                                                    input logic signed [C_W-1:0] c_im,
                                                    input logic [CNT_W-1:0] limit);
    longint zr;
    longint zi;
    longint nr;
    longint ni;
    int unsigned steps;
    logic escaped;
    escape_result_t res;
    zr = 0;
    zi = 0;
    steps = 0;
    escaped = 1'b0;
    while (steps < limit && !escaped) begin
      // Form the squares only once both components are below 2.
      escaped = (zr >= ESCAPE_MAG) || (-zr >= ESCAPE_MAG) ||
                (zi >= ESCAPE_MAG) || (-zi >= ESCAPE_MAG);
      if (!escaped)
        escaped = (zr * zr + zi * zi) >= ESCAPE_SQ;
      if (!escaped) begin
        nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + longint'(c_re);
        ni = ((2 * zr * zi) >>> FRAC_BITS) + longint'(c_im);
        zr = nr;
        zi = ni;
        steps++;
      end
    end
    res.iterations = steps[CNT_W-1:0];
    res.inside_set = (steps == limit);
    res.final_real = zr[Z_W-1:0];
    res.final_imag = zi[Z_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: result %0d %s: got %0d, expected %0d",
               $time, results_seen, what, got, want);
  endtask

  // Offer one point; hold valid high across back-to-back points and drop it
  // only on an idle cycle.
  task automatic send_point(input logic signed [C_W-1:0] c_re,
                            input logic signed [C_W-1:0] c_im);
    while ($urandom_range(99) < idle_pct) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
    end
    point_ch.valid  <= 1'b1;
    point_ch.c_real <= c_re;
    point_ch.c_imag <= c_im;
    do @(posedge clk); while (!point_ch.ready);
    pending_results.push_back(predict_escape(c_re, c_im, iter_limit));
    points_sent++;
  endtask

  // Drop valid and hold until every pending result has been taken.
  task automatic wait_results_drained();
    point_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the iteration limit; only called with the unit idle.
  task automatic write_iter_limit(input logic [CNT_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    iter_limit = limit;
    limits_used++;
  endtask

  // Mostly points around the set boundary, with some full-range noise.
  task automatic send_random_point();
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
    if ($urandom_range(99) < 80) begin
      c_re = int'($urandom_range(NEAR_SPAN)) - NEAR_RE_LOW;
      c_im = int'($urandom_range(NEAR_SPAN)) - NEAR_IM_LOW;
    end else begin
      c_re = $urandom;
      c_im = $urandom;
    end
    send_point(c_re, c_im);
  endtask

  // Corner points at the reset limit of 20.
  task automatic test_corner_points();
    send_point(0, 0);                        // origin, never escapes
    send_point(C_MIN, C_MIN);                // most negative c, escapes after the first step
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MAX);
    send_point(C_MAX, 0);
    send_point(0, C_MIN);
    send_point(-2 * Q_ONE, 0);               // tip of the set, |z| lands on 2
    send_point(0, 2 * Q_ONE);                // imag exactly 2
    send_point(2 * Q_ONE - 1, 0);
    send_point(Q_ONE / 4, 0);                // cusp, slow convergence
    send_point(Q_ONE / 4 + Q_ONE / 100, 0);  // just outside the cusp
    send_point(-Q_ONE, 0);                   // z alternates between 0 and -1
    send_point(0, Q_ONE);                    // preperiodic point on the boundary
    send_point(0, -Q_ONE);
    send_point(-(3 * Q_ONE) / 4, Q_ONE / 10);
    send_point(-(7 * Q_ONE) / 4, 0);
    send_point(-1, -1);                      // tiny negatives exercise floor rounding
    wait_results_drained();
  endtask

  // Limit of 1, 0 and 255.
  task automatic test_limit_extremes();
    write_iter_limit(8'd1);
    send_point(0, 0);
    send_point(C_MIN, C_MAX);
    repeat (6) send_random_point();
    wait_results_drained();

    // Zero limit: every point reports zero steps, inside set, z = 0.
    write_iter_limit(8'd0);
    send_point(0, 0);
    send_point(C_MAX, C_MIN);
    repeat (4) send_random_point();
    wait_results_drained();

    write_iter_limit(8'd255);
    send_point(0, 0);
    send_point(-Q_ONE, 0);
    send_point(Q_ONE / 4, 0);
    send_point(0, Q_ONE);
    repeat (12) send_random_point();
    wait_results_drained();
  endtask

  // Random points at a random limit, with one full drain halfway through.
  task automatic test_random_points(input int src_idle, input int sink_stall,
                                    input int count);
    idle_pct  = src_idle;
    stall_pct = sink_stall;
    write_iter_limit(CNT_W'($urandom_range(2, 48)));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_results_drained();
      send_random_point();
    end
    wait_results_drained();
  endtask

  // Result side: stall at the configured rate.
  always @(posedge clk) begin
    if (rst)
      result_ch.ready <= 1'b0;
    else
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result against the oldest pending prediction.
  always @(posedge clk) begin
    escape_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("arrived with nothing pending, iterations",
                        result_ch.iterations, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_ch.iterations !== want.iterations)
          report_mismatch("iterations", result_ch.iterations, want.iterations);
        if (result_ch.inside_set !== want.inside_set)
          report_mismatch("inside_set", result_ch.inside_set, want.inside_set);
        if (result_ch.final_real !== want.final_real)
          report_mismatch("final_real", result_ch.final_real, want.final_real);
        if (result_ch.final_imag !== want.final_imag)
          report_mismatch("final_imag", result_ch.final_imag, want.final_imag);
        if (want.inside_set)
          inside_seen++;
        if (int'(want.iterations) > deepest_count)
          deepest_count = int'(want.iterations);
      end
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    point_ch.valid   = 1'b0;
    point_ch.c_real  = '0;
    point_ch.c_imag  = '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_corner_points();
    test_limit_extremes();
    test_random_points(0, 0, 140);
    test_random_points(59, 0, 140);
    test_random_points(0, 59, 140);
    test_random_points(32, 32, 140);

    // Let one more point's worth of cycles pass to catch stray results.
    repeat (5 * int'(iter_limit) + 16) @(posedge clk);

    $display("Ran %0d points under %0d iteration limits (0, 1, 20, 255 and random);",
             points_sent, limits_used);
    $display("%0d results checked, %0d inside the set, deepest count %0d.",
             results_seen, inside_seen, deepest_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[mandelbrot_escape_time_unit] OK");
    end else begin
      $display("[mandelbrot_escape_time_unit] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(6_000_000);
    $display("[mandelbrot_escape_time_unit] ERROR");
    $finish;
  end

endmodule
